FILE: design/euc_dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package euc_dec_pkg;

   localparam int LEN_W     = 3;
   localparam int CODE_W    = 30;
   localparam int PARTIAL_W = 28;
   localparam int TAG_W     = 2;

   localparam logic [7:0] BYTE_SS2 = 8'h8E;
   localparam logic [7:0] BYTE_SS3 = 8'h8F;
   localparam logic [7:0] C1_LOW   = 8'h80;
   localparam logic [7:0] C1_HIGH  = 8'h9F;

   localparam logic [TAG_W-1:0] TAG_NONE = 2'd0;
   localparam logic [TAG_W-1:0] TAG_CS1  = 2'd3;
   localparam logic [TAG_W-1:0] TAG_CS2  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_CS3  = 2'd2;

   localparam logic [LEN_W-1:0] CS1_RESET_LEN = 3'd2;
   localparam logic [LEN_W-1:0] CS2_RESET_LEN = 3'd1;
   localparam logic [LEN_W-1:0] CS3_RESET_LEN = 3'd2;

   typedef enum logic [1:0] {
      CSR_CS1_LENGTH = 2'd0,
      CSR_CS2_LENGTH = 2'd1,
      CSR_CS3_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_ILLEGAL = 2'd1,
      KIND_EOS     = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   wide_code;
      logic                last;
   } result_type;

endpackage
`default_nettype wire

FILE: design/euc_dec_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface euc_dec_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: design/euc_dec_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface euc_dec_rsp_if
   import euc_dec_pkg::*;
   ;
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [CODE_W-1:0] wide_code;
   logic              last;

   modport source (output valid, output kind, output wide_code, output last, input ready);
   modport sink (input valid, input kind, input wide_code, input last, output ready);
endinterface
`default_nettype wire

FILE: design/euc_multibyte_to_wide_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// channel    direction  transaction
// req_chan   in         one byte (action 0) or end of stream (action 1)
// rsp_chan   out        one result: kind, wide_code, last
// csr_*      in         register write, index and 3-bit data, no read-back
//
// one byte per clock: decoding is a single pass from the decoder state
// into a four-entry result queue, which also absorbs the second result
// of an illegal sequence. req_chan.ready is high while two queue entries
// are free, so the rate is one transaction per cycle unless rsp_chan
// stalls. synchronous reset clears the decoder state and the queue and
// loads the register reset lengths.
module euc_multibyte_to_wide_decoder
   import euc_dec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   euc_dec_req_if.sink           req_chan,
   euc_dec_rsp_if.source         rsp_chan,
   input  wire logic             csr_write_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [LEN_W-1:0] csr_write_data
);

   logic [LEN_W-1:0]     cs1_len_ff, cs2_len_ff, cs3_len_ff;
   logic [LEN_W-1:0]     bytes_left_ff, bytes_left_in;
   logic [PARTIAL_W-1:0] partial_ff, partial_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;

   result_type           queue_mem [4];
   logic [1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [2:0]           count_ff;

   logic                 accept, pop;
   logic                 eos;
   logic [7:0]           b;
   logic                 illegal;

   logic                 idle_has;
   result_type           idle_res;
   logic [LEN_W-1:0]     idle_left;
   logic [PARTIAL_W-1:0] idle_partial;
   logic [TAG_W-1:0]     idle_tag;

   logic [PARTIAL_W-1:0] shifted;
   logic [LEN_W-1:0]     left_dec;
   result_type           res0, res1;
   logic [1:0]           num_res;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign eos    = req_chan.action;
   assign b      = req_chan.data_byte;

   assign req_chan.ready     = (count_ff <= 3'd2);
   assign rsp_chan.valid     = (count_ff != 3'd0);
   assign rsp_chan.kind      = queue_mem[rd_ptr_ff].kind;
   assign rsp_chan.wide_code = queue_mem[rd_ptr_ff].wide_code;
   assign rsp_chan.last      = queue_mem[rd_ptr_ff].last;

   // decode with no character in progress
   always_comb begin
      idle_has          = 1'b0;
      idle_res.kind     = KIND_CHAR;
      idle_res.wide_code = '0;
      idle_res.last     = 1'b1;
      idle_left         = '0;
      idle_partial      = '0;
      idle_tag          = TAG_NONE;
      if (eos) begin
         idle_has      = 1'b1;
         idle_res.kind = KIND_EOS;
      end else if (b < C1_LOW) begin
         idle_has           = 1'b1;
         idle_res.wide_code = CODE_W'(b);
      end else if (b == BYTE_SS2 && cs2_len_ff != '0) begin
         idle_left = cs2_len_ff;
         idle_tag  = TAG_CS2;
      end else if (b == BYTE_SS3 && cs3_len_ff != '0) begin
         idle_left = cs3_len_ff;
         idle_tag  = TAG_CS3;
      end else if (b <= C1_HIGH || cs1_len_ff == '0) begin
         idle_has           = 1'b1;
         idle_res.wide_code = CODE_W'(b);
      end else if (cs1_len_ff == LEN_W'(1)) begin
         idle_has           = 1'b1;
         idle_res.wide_code = {TAG_CS1, (PARTIAL_W-7)'(0), b[6:0]};
      end else begin
         idle_left    = cs1_len_ff - LEN_W'(1);
         idle_partial = PARTIAL_W'(b[6:0]);
         idle_tag     = TAG_CS1;
      end
   end

   // continuation, error and idle paths
   always_comb begin
      illegal        = (bytes_left_ff != '0) && (eos || b <= C1_HIGH);
      shifted        = {partial_ff[PARTIAL_W-8:0], b[6:0]};
      left_dec       = bytes_left_ff - LEN_W'(1);
      res0.kind      = KIND_CHAR;
      res0.wide_code = '0;
      res0.last      = 1'b1;
      res1           = idle_res;
      num_res        = 2'd0;
      bytes_left_in  = idle_left;
      partial_in     = idle_partial;
      tag_in         = idle_tag;
      if (bytes_left_ff == '0) begin
         res0    = idle_res;
         num_res = {1'b0, idle_has};
      end else if (illegal) begin
         res0.kind = KIND_ILLEGAL;
         res0.last = !idle_has;
         num_res   = idle_has ? 2'd2 : 2'd1;
      end else if (left_dec == '0) begin
         res0.wide_code = {tag_ff, shifted};
         num_res        = 2'd1;
         bytes_left_in  = '0;
         partial_in     = '0;
         tag_in         = TAG_NONE;
      end else begin
         bytes_left_in = left_dec;
         partial_in    = shifted;
         tag_in        = tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs1_len_ff    <= CS1_RESET_LEN;
         cs2_len_ff    <= CS2_RESET_LEN;
         cs3_len_ff    <= CS3_RESET_LEN;
         bytes_left_ff <= '0;
         partial_ff    <= '0;
         tag_ff        <= TAG_NONE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CS1_LENGTH: cs1_len_ff <= csr_write_data;
               CSR_CS2_LENGTH: cs2_len_ff <= csr_write_data;
               CSR_CS3_LENGTH: cs3_len_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            bytes_left_ff <= bytes_left_in;
            partial_ff    <= partial_in;
            tag_ff        <= tag_in;
            wr_ptr_ff     <= wr_ptr_ff + num_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, num_res} : 3'd0) - {2'b00, pop};
      end
   end

   // result queue payload
   always_ff @(posedge clock) begin
      if (accept && num_res != 2'd0) begin
         queue_mem[wr_ptr_ff] <= res0;
      end
      if (accept && num_res == 2'd2) begin
         queue_mem[wr_ptr_ff + 2'd1] <= res1;
      end
   end

endmodule
`default_nettype wire

FILE: tb/euc_dec_checker.sv
`timescale 1ns / 1ps
module euc_dec_checker
   import euc_dec_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   euc_dec_req_if                req_chan,
   euc_dec_rsp_if                rsp_chan,
   input  wire logic             csr_write_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [LEN_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int REPORT_LIMIT = 10;

   logic [LEN_W-1:0]     cs1_len;
   logic [LEN_W-1:0]     cs2_len;
   logic [LEN_W-1:0]     cs3_len;
   logic [LEN_W-1:0]     bytes_left;
   logic [PARTIAL_W-1:0] partial_code;
   logic [TAG_W-1:0]     set_tag;
   result_type           awaited_results[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic void push_result(kind_type k, logic [CODE_W-1:0] code);
      result_type r;
      r.kind      = k;
      r.wide_code = code;
      r.last      = 1'b0;
      awaited_results.push_back(r);
   endfunction

   // decode with no character open, returns the number of results
   function automatic int open_char(logic eos, logic [7:0] b);
      if (eos) begin
         push_result(KIND_EOS, '0);
         return 1;
      end
      if (b < C1_LOW) begin
         push_result(KIND_CHAR, CODE_W'(b));
         return 1;
      end
      if (b == BYTE_SS2 && cs2_len != '0) begin
         bytes_left   = cs2_len;
         partial_code = '0;
         set_tag      = TAG_CS2;
         return 0;
      end
      if (b == BYTE_SS3 && cs3_len != '0) begin
         bytes_left   = cs3_len;
         partial_code = '0;
         set_tag      = TAG_CS3;
         return 0;
      end
      if (b <= C1_HIGH || cs1_len == '0) begin
         push_result(KIND_CHAR, CODE_W'(b));
         return 1;
      end
      if (cs1_len == LEN_W'(1)) begin
         push_result(KIND_CHAR, {TAG_CS1, 21'd0, b[6:0]});
         return 1;
      end
      bytes_left   = cs1_len - LEN_W'(1);
      partial_code = PARTIAL_W'(b[6:0]);
      set_tag      = TAG_CS1;
      return 0;
   endfunction

   function automatic void decode_item(logic eos, logic [7:0] b);
      int n;
      n = 0;
      if (bytes_left == '0) begin
         n = open_char(eos, b);
      end else if (eos || b <= C1_HIGH) begin
         push_result(KIND_ILLEGAL, '0);
         bytes_left   = '0;
         partial_code = '0;
         set_tag      = TAG_NONE;
         n = 1 + open_char(eos, b);
      end else begin
         partial_code = {partial_code[PARTIAL_W-8:0], b[6:0]};
         bytes_left   = bytes_left - LEN_W'(1);
         if (bytes_left == '0) begin
            push_result(KIND_CHAR, {set_tag, partial_code});
            partial_code = '0;
            set_tag      = TAG_NONE;
            n = 1;
         end
      end
      if (n > 0) begin
         awaited_results[awaited_results.size()-1].last = 1'b1;
      end
   endfunction

   function automatic void check_result();
      result_type want;
      if (awaited_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result kind %0d code %08h last %0d", $realtime,
                     rsp_chan.kind, rsp_chan.wide_code, rsp_chan.last);
         end
         return;
      end
      want = awaited_results.pop_front();
      if (want.kind != rsp_chan.kind || want.wide_code != rsp_chan.wide_code
          || want.last != rsp_chan.last) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected kind %0d code %08h last %0d, got %0d %08h %0d",
                     $realtime, want.kind, want.wide_code, want.last,
                     rsp_chan.kind, rsp_chan.wide_code, rsp_chan.last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cs1_len      = CS1_RESET_LEN;
         cs2_len      = CS2_RESET_LEN;
         cs3_len      = CS3_RESET_LEN;
         bytes_left   = '0;
         partial_code = '0;
         set_tag      = TAG_NONE;
         awaited_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CS1_LENGTH: cs1_len = csr_write_data;
               CSR_CS2_LENGTH: cs2_len = csr_write_data;
               CSR_CS3_LENGTH: cs3_len = csr_write_data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            decode_item(req_chan.action, req_chan.data_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_result();
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import euc_dec_pkg::*;

   localparam logic ACT_DATA     = 1'b0;
   localparam logic ACT_EOS      = 1'b1;
   localparam int   DRAIN_CYCLES = 10;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   IDLE_LIMIT   = 2000;

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [1:0]       csr_index;
   logic [LEN_W-1:0] csr_write_data;
   int               mismatch_count;
   int               pending_count;

   logic [LEN_W-1:0] cs1_len;
   logic [LEN_W-1:0] cs2_len;
   logic [LEN_W-1:0] cs3_len;
   int               sent_count;
   int               idle_cycles;
   bit               no_idle;
   bit               hold_now;

   euc_dec_req_if req_chan_if();
   euc_dec_rsp_if rsp_chan_if();

   euc_multibyte_to_wide_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan_if),
      .rsp_chan       (rsp_chan_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   euc_dec_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan_if),
      .rsp_chan       (rsp_chan_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_chan_if.valid && req_chan_if.ready)
                   || (rsp_chan_if.valid && rsp_chan_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_chan_if.ready = 1'b0;
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            rsp_chan_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
               rsp_chan_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan_if.valid);
      end
   end

   task automatic send_item(input logic act, input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan_if.valid     <= 1'b1;
      req_chan_if.action    <= act;
      req_chan_if.data_byte <= b;
      do @(posedge clock); while (!req_chan_if.ready);
      sent_count++;
   endtask

   task automatic settle();
      req_chan_if.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_lengths(input logic [LEN_W-1:0] l1, input logic [LEN_W-1:0] l2,
                              input logic [LEN_W-1:0] l3);
      settle();
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_CS1_LENGTH;
      csr_write_data <= l1;
      @(posedge clock);
      csr_index      <= CSR_CS2_LENGTH;
      csr_write_data <= l2;
      @(posedge clock);
      csr_index      <= CSR_CS3_LENGTH;
      csr_write_data <= l3;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cs1_len = l1;
      cs2_len = l2;
      cs3_len = l3;
   endtask

   // lead byte of a random code set and the bytes still owed after it
   task automatic pick_char(output logic [7:0] lead, output int need);
      case ($urandom_range(0, 2))
         0: begin
            lead = 8'($urandom_range(160, 255));
            need = (cs1_len == '0) ? 0 : int'(cs1_len) - 1;
         end
         1: begin
            lead = BYTE_SS2;
            need = int'(cs2_len);
         end
         default: begin
            lead = BYTE_SS3;
            need = int'(cs3_len);
         end
      endcase
   endtask

   task automatic send_random_unit();
      int         pick;
      int         need;
      int         cut;
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         send_item(ACT_DATA, 8'($urandom_range(0, 127)));
      end else if (pick < 36) begin
         send_item(ACT_DATA, 8'($urandom_range(128, 159)));
      end else if (pick < 41) begin
         send_item(ACT_EOS, 8'($urandom));
      end else if (pick < 80) begin
         pick_char(lead, need);
         send_item(ACT_DATA, lead);
         repeat (need) send_item(ACT_DATA, 8'($urandom_range(160, 255)));
      end else if (pick < 92) begin
         // character cut short by a control byte, ascii or end of stream
         pick_char(lead, need);
         send_item(ACT_DATA, lead);
         cut = (need == 0) ? 0 : $urandom_range(0, need - 1);
         repeat (cut) send_item(ACT_DATA, 8'($urandom_range(160, 255)));
         if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_EOS, 8'($urandom));
         end else begin
            send_item(ACT_DATA, 8'($urandom_range(0, 159)));
         end
      end else begin
         send_item(1'($urandom), 8'($urandom));
      end
   endtask

   task automatic run_random(input int count);
      int first;
      first = sent_count;
      while (sent_count - first < count) send_random_unit();
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan_if.valid     = 1'b0;
      req_chan_if.action    = ACT_DATA;
      req_chan_if.data_byte = 8'h00;
      csr_write_en          = 1'b0;
      csr_index             = CSR_CS1_LENGTH;
      csr_write_data        = '0;
      cs1_len               = CS1_RESET_LEN;
      cs2_len               = CS2_RESET_LEN;
      cs3_len               = CS3_RESET_LEN;
      sent_count            = 0;
      idle_cycles           = 0;
      no_idle               = 1'b0;
      hold_now              = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset lengths: ascii and c1 edges, each code set, broken characters
      send_item(ACT_DATA, 8'h00);
      send_item(ACT_DATA, 8'h7F);
      send_item(ACT_DATA, 8'h80);
      send_item(ACT_DATA, 8'h9F);
      send_item(ACT_DATA, BYTE_SS2);
      send_item(ACT_DATA, 8'hA1);
      send_item(ACT_DATA, BYTE_SS3);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hA0);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hFF);
      send_item(ACT_DATA, 8'hB0);
      send_item(ACT_DATA, 8'h41);
      send_item(ACT_DATA, 8'hB0);
      send_item(ACT_DATA, 8'h85);
      send_item(ACT_DATA, BYTE_SS3);
      send_item(ACT_EOS, 8'h00);
      send_item(ACT_DATA, 8'hC1);
      send_item(ACT_DATA, BYTE_SS2);
      send_item(ACT_DATA, 8'hA2);
      send_item(ACT_EOS, 8'hFF);
      run_random(160);

      // single-byte code set 1, code sets 2 and 3 undefined
      set_lengths(3'd1, 3'd0, 3'd0);
      send_item(ACT_DATA, BYTE_SS2);
      send_item(ACT_DATA, BYTE_SS3);
      send_item(ACT_DATA, 8'hA5);
      run_random(160);

      // code set 1 undefined, back to back with no idling
      set_lengths(3'd0, 3'd4, 3'd4);
      no_idle = 1'b1;
      send_item(ACT_DATA, 8'hC3);
      run_random(160);

      // long hold-off on the result side while bytes keep coming
      set_lengths(3'd4, 3'd2, 3'd3);
      hold_now = 1'b1;
      run_random(160);
      no_idle = 1'b0;

      set_lengths(3'd7, 3'd5, 3'd6);
      run_random(160);

      set_lengths(3'd3, 3'd7, 3'd7);
      run_random(160);

      set_lengths(CS1_RESET_LEN, CS2_RESET_LEN, CS3_RESET_LEN);
      run_random(165);

      settle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
